// ===== sv/ple_pkg.sv =====
package ple_pkg;

  // Payload widths of the two channels.
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int CNT_W = 7;
  localparam int ST_W  = 2;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  // Status codes carried by a result beat.
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

endpackage

// ===== sv/ple_if.sv =====
// Input channel: one operation per beat.
interface ple_in_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);
endinterface

// Result channel: status beats and dump beats.
interface ple_out_if;
  import ple_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] entry;
  logic [CNT_W-1:0]        count;
  logic                    last;

  modport source (output valid, status, entry, count, last, input ready);
  modport sink   (input valid, status, entry, count, last, output ready);
endinterface

// ===== sv/ple_ram.sv =====
module ple_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port; the read port registers its data and holds it when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/positional_list_engine_unit.sv =====
// Channel  Modport      Beat contents
// in_ch    ple_in_if    op, value, position
// out_ch   ple_out_if   status, entry, count, last
//
// A status-only operation goes from acceptance to S_RESP, which registers its result beat.
// An insert or a delete at zero-based slot k shifts the entries that lie behind that slot,
// as entries move by one slot a cycle through one memory read and one write.
// A dump gives one beat a cycle from the memory read port while the output is not stalled.
// A new operation is taken only once the previous one has finished; output stalls hold the
// block at its last beat. Synchronous reset empties the list; the memory is not cleared.
module positional_list_engine_unit #(
  parameter int DEPTH = 64
) (
  input logic      clk,
  input logic      rst_n,
  ple_in_if.sink   in_ch,
  ple_out_if.source out_ch
);
  import ple_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_INS, S_DEL, S_DUMP, S_RESP} state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           w_r, w_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  status_t                 status_r, status_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_entry_r, out_entry_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VAL_W-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [VAL_W-1:0]        ram_rdata;

  logic                    accept;
  logic                    out_free;
  logic [POS_W:0]          pos_x;
  logic [POS_W:0]          count_x;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign pos_x    = {1'b0, in_ch.position};
  assign count_x  = (POS_W + 1)'(count_r);

  // Entry store.
  ple_ram #(.DEPTH(DEPTH), .WIDTH(VAL_W)) u_ple_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: decode, shift loops, dump and result beats.
  always_comb begin
    logic          ins_go;
    logic          del_go;
    logic [AW-1:0] ins_idx;
    logic [AW-1:0] del_idx;

    ins_go         = 1'b0;
    del_go         = 1'b0;
    ins_idx        = '0;
    del_idx        = '0;
    state_nxt      = state_r;
    count_nxt      = count_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = w_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt    = in_ch.value;
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          case (in_ch.op)
            OP_INS_FIRST, OP_INS_LAST: begin
              if (count_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                ins_go  = 1'b1;
                ins_idx = (in_ch.op == OP_INS_FIRST) ? '0 : count_r[AW-1:0];
              end
            end
            OP_INS_AT: begin
              if (pos_x == '0 || pos_x > count_x + 1'b1) begin
                status_nxt = ST_BADPOS;
              end else if (count_r == FULL_CNT) begin
                status_nxt = ST_FULL;
              end else begin
                ins_go  = 1'b1;
                ins_idx = AW'(in_ch.position - 1'b1);
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                del_go  = 1'b1;
                del_idx = (in_ch.op == OP_DEL_FIRST) ? '0 : AW'(count_r - 1'b1);
              end
            end
            OP_DEL_AT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > count_x) begin
                status_nxt = ST_BADPOS;
              end else begin
                del_go  = 1'b1;
                del_idx = AW'(in_ch.position - 1'b1);
              end
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                w_nxt     = '0;
                state_nxt = S_DUMP;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase

          // Insert walks down from the tail, reading one slot ahead of the write.
          if (ins_go) begin
            idx_nxt   = ins_idx;
            w_nxt     = count_r[AW-1:0];
            ram_re    = 1'b1;
            ram_raddr = count_r[AW-1:0] - 1'b1;
            state_nxt = S_INS;
          end

          // Delete walks up from the removed slot.
          if (del_go) begin
            w_nxt     = del_idx;
            ram_re    = 1'b1;
            ram_raddr = del_idx + 1'b1;
            state_nxt = S_DEL;
          end
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = w_r;
        if (w_r == idx_r) begin
          ram_wdata = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_wdata = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = w_r - AW'(2);
          w_nxt     = w_r - 1'b1;
        end
      end

      S_DEL: begin
        if (CW'(w_r) == count_r - 1'b1) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = w_r;
          ram_wdata = ram_rdata;
          ram_re    = 1'b1;
          ram_raddr = w_r + AW'(2);
          w_nxt     = w_r + 1'b1;
        end
      end

      // The read data register holds its entry while the output is stalled.
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_entry_nxt  = ram_rdata;
          out_count_nxt  = CNT_W'(count_r);
          out_last_nxt   = (CW'(w_r) == count_r - 1'b1);
          if (CW'(w_r) == count_r - 1'b1) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = w_r + 1'b1;
            w_nxt     = w_r + 1'b1;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_entry_nxt  = '0;
          out_count_nxt  = CNT_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r          <= w_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.entry  = out_entry_r;
  assign out_ch.count  = out_count_r;
  assign out_ch.last   = out_last_r;

endmodule

// ===== sv/ple_checker.sv =====
module ple_checker #(
  parameter int DEPTH = 64
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ple_pkg::ST_W-1:0]        out_status,
  input logic signed [ple_pkg::VAL_W-1:0] out_entry,
  input logic [ple_pkg::CNT_W-1:0]       out_count,
  input logic                            out_last
);
  import ple_pkg::*;

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry) &&
      $stable(out_status) && $stable(out_count) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Only a dump gives beats before the last one, and those are ok and non-empty.
  a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK && out_count != '0)
    else $error("non-final beat without an ok dump entry");

  // Error beats carry no entry.
  a_err_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_entry == '0)
    else $error("error beat carries an entry");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= DEPTH)
    else $error("count above capacity");

  // Reset removes any pending result beat.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind positional_list_engine_unit ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_entry  (out_ch.entry),
  .out_count  (out_ch.count),
  .out_last   (out_ch.last)
);
